@@ src/aes128_block_cipher_defines.svh @@
// assertion macros for the aes-128 engine
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AES_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AES_ASSERT_IMP(label, clk, rst, ante, cons)
`define AES_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/aes_pkg.sv @@
`timescale 1ns / 1ps
package aes_pkg;

  localparam int NUM_ROUND_KEYS = 11;
  localparam int LAST_ROUND = NUM_ROUND_KEYS - 1;
  localparam int ROUND_W = $clog2(NUM_ROUND_KEYS);

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW = 1'b1;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  // datapath commands from the controller
  typedef struct packed {
    logic load;                  // take the input block, add the first round key
    logic step;                  // run one round
    logic dec;                   // decrypt direction
    logic [ROUND_W-1:0] round;   // round index of the step, 0..10
    logic key_start;             // start key expansion
    logic capture;               // copy the finished block to the output register
  } aes_cmd_t;

  typedef struct packed {
    logic key_busy;
  } aes_stat_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
    rotl = (v << n) | (v >> (8 - n));
  endfunction

  // GF(2^8) inverse by x^254, square-and-multiply, then affine map
  function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul8 = p;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] base;
    inv = 8'h01;
    base = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) inv = gmul8(inv, base);
      base = gmul8(base, base);
    end
    if (x == 8'h00) inv = 8'h00;
    sbox_calc = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t build_fwd();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
    return t;
  endfunction

  function automatic sbox_t build_inv();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[sbox_calc(8'(i))] = 8'(i);
    return t;
  endfunction

  localparam sbox_t FWD_SBOX = build_fwd();
  localparam sbox_t DEC_SBOX = build_inv();

  // byte i of a 128-bit word, byte 0 at the top
  function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
    byte_of = w[127 - 8*i -: 8];
  endfunction

endpackage

@@ src/aes_ram.sv @@
`timescale 1ns / 1ps
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ src/aes_datapath.sv @@
`timescale 1ns / 1ps
module aes_datapath (
  input  logic             clk,
  input  logic             rst,
  input  aes_pkg::aes_cmd_t cmd,
  output aes_pkg::aes_stat_t stat,
  input  logic [127:0]     key,
  input  logic [127:0]     block_in,
  input  logic [aes_pkg::ROUND_W-1:0] rk_addr,
  output logic [127:0]     state_out
);

  logic [127:0] state;
  logic [127:0] res;
  logic [127:0] rk;

  // key expansion: one round key per cycle into the key ram
  logic [127:0] kx;
  logic [127:0] kx_next;
  logic [7:0] rcon;
  logic [aes_pkg::ROUND_W-1:0] kcnt;
  logic kbusy;
  logic kwe;
  logic [aes_pkg::ROUND_W-1:0] kaddr;
  logic [127:0] kdata;

  always_comb begin
    logic [31:0] t;
    t = {aes_pkg::FWD_SBOX[aes_pkg::byte_of(kx, 13)] ^ rcon,
         aes_pkg::FWD_SBOX[aes_pkg::byte_of(kx, 14)],
         aes_pkg::FWD_SBOX[aes_pkg::byte_of(kx, 15)],
         aes_pkg::FWD_SBOX[aes_pkg::byte_of(kx, 12)]};
    kx_next[127:96] = kx[127:96] ^ t;
    kx_next[95:64] = kx[95:64] ^ kx_next[127:96];
    kx_next[63:32] = kx[63:32] ^ kx_next[95:64];
    kx_next[31:0] = kx[31:0] ^ kx_next[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kbusy <= 1'b0;
      kcnt <= '0;
    end else if (cmd.key_start) begin
      kbusy <= 1'b1;
      kcnt <= '0;
    end else if (kbusy) begin
      if (kcnt == aes_pkg::ROUND_W'(aes_pkg::LAST_ROUND)) kbusy <= 1'b0;
      kcnt <= kcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      kx <= key;
      rcon <= 8'h01;
    end else if (kbusy && kcnt != '0) begin
      kx <= kx_next;
      rcon <= aes_pkg::xtime(rcon);
    end
  end

  assign kwe = kbusy;
  assign kaddr = kcnt;
  assign kdata = (kcnt == '0) ? kx : kx_next;
  assign stat.key_busy = kbusy | cmd.key_start;

  aes_ram #(.WIDTH(128), .DEPTH(aes_pkg::NUM_ROUND_KEYS)) u_keys (
    .clk(clk), .we(kwe), .waddr(kaddr), .wdata(kdata), .raddr(rk_addr), .rdata(rk)
  );

  // round logic
  logic [127:0] fsb, fsr, fmc, isr, isb, ark, imc, rnd;
  logic last;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      fsb[127-8*i -: 8] = aes_pkg::FWD_SBOX[aes_pkg::byte_of(state, i)];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fsr[127-8*(c*4+r) -: 8] = aes_pkg::byte_of(fsb, ((c+r)%4)*4+r);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = aes_pkg::byte_of(fsr, c*4);
      a1 = aes_pkg::byte_of(fsr, c*4+1);
      a2 = aes_pkg::byte_of(fsr, c*4+2);
      a3 = aes_pkg::byte_of(fsr, c*4+3);
      fmc[127-32*c -: 32] = {
        aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3,
        a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3,
        a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3,
        aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3)};
    end
    // decrypt round: add key, inv mix, inv shift, inv sub (the last round only adds the key)
    ark = state ^ rk;
    for (int c = 0; c < 4; c++) begin
      logic [7:0] b0, b1, b2, b3;
      b0 = aes_pkg::byte_of(ark, c*4);
      b1 = aes_pkg::byte_of(ark, c*4+1);
      b2 = aes_pkg::byte_of(ark, c*4+2);
      b3 = aes_pkg::byte_of(ark, c*4+3);
      imc[127-32*c -: 32] = {
        aes_pkg::gmul(b0, 8'h0e) ^ aes_pkg::gmul(b1, 8'h0b) ^
          aes_pkg::gmul(b2, 8'h0d) ^ aes_pkg::gmul(b3, 8'h09),
        aes_pkg::gmul(b0, 8'h09) ^ aes_pkg::gmul(b1, 8'h0e) ^
          aes_pkg::gmul(b2, 8'h0b) ^ aes_pkg::gmul(b3, 8'h0d),
        aes_pkg::gmul(b0, 8'h0d) ^ aes_pkg::gmul(b1, 8'h09) ^
          aes_pkg::gmul(b2, 8'h0e) ^ aes_pkg::gmul(b3, 8'h0b),
        aes_pkg::gmul(b0, 8'h0b) ^ aes_pkg::gmul(b1, 8'h0d) ^
          aes_pkg::gmul(b2, 8'h09) ^ aes_pkg::gmul(b3, 8'h0e)};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        isr[127-8*(((c+r)%4)*4+r) -: 8] = aes_pkg::byte_of(imc, c*4+r);
      end
    end
    for (int i = 0; i < 16; i++) begin
      isb[127-8*i -: 8] = aes_pkg::DEC_SBOX[aes_pkg::byte_of(isr, i)];
    end
  end

  // decrypt: initial step is key10 then inv shift/sub, handled as a round
  // with no inv mix; final step is plain key 0 addition
  always_comb begin
    last = (cmd.round == aes_pkg::ROUND_W'(aes_pkg::LAST_ROUND));
    if (!cmd.dec) begin
      rnd = (last ? fsr : fmc) ^ rk;
    end else if (last) begin
      rnd = ark;
    end else begin
      rnd = isb;
    end
  end

  // input block with the first round key (key 0 or key 10) added
  logic [127:0] blk_key;
  assign blk_key = block_in ^ rk;

  // inverse mix is skipped on the first decrypt round: feed blk_key straight
  logic [127:0] isr0, isb0;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        isr0[127-8*(((c+r)%4)*4+r) -: 8] = aes_pkg::byte_of(blk_key, c*4+r);
      end
    end
    for (int i = 0; i < 16; i++) begin
      isb0[127-8*i -: 8] = aes_pkg::DEC_SBOX[aes_pkg::byte_of(isr0, i)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      res <= '0;
    end else begin
      if (cmd.load) begin
        state <= blk_key;
      end else if (cmd.step) begin
        state <= (cmd.dec && cmd.round == '0) ? isb0 : rnd;
      end
      if (cmd.capture) res <= state;
    end
  end

  assign state_out = res;

endmodule

@@ src/aes_ctrl.sv @@
`timescale 1ns / 1ps
module aes_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               in_fire,
  input  logic               in_kind,
  input  logic               out_fire,
  input  aes_pkg::aes_stat_t stat,
  output aes_pkg::aes_cmd_t  cmd,
  output logic [aes_pkg::ROUND_W-1:0] rk_addr,
  output logic               in_ready,
  output logic               out_valid,
  output logic               cfg_ready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t st, st_next;
  logic dec;
  logic [aes_pkg::ROUND_W-1:0] rnd;
  logic kstart;
  logic out_full;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      kstart <= 1'b1;
    end else begin
      kstart <= cfg_write;
    end
  end

  // finished block moves to the output register once that is free
  assign take = (st == S_DONE) && (!out_full || out_fire);

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: if (in_fire) st_next = S_ADD;
      S_ADD: st_next = S_RUN;
      S_RUN: if (rnd == aes_pkg::ROUND_W'(aes_pkg::LAST_ROUND)) st_next = S_DONE;
      S_DONE: if (take) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      dec <= 1'b0;
      rnd <= '0;
      out_full <= 1'b0;
    end else begin
      st <= st_next;
      if (in_fire) begin
        dec <= in_kind;
        rnd <= '0;
      end else if (st == S_ADD || st == S_RUN) begin
        rnd <= rnd + 1'b1;
      end
      if (take) begin
        out_full <= 1'b1;
      end else if (out_fire) begin
        out_full <= 1'b0;
      end
    end
  end

  // key read is issued in the cycle before its use: the ram read is registered
  always_comb begin
    logic [aes_pkg::ROUND_W-1:0] nr;
    nr = in_fire ? '0 : rnd + 1'b1;
    if (in_fire) begin
      rk_addr = in_kind ? aes_pkg::ROUND_W'(aes_pkg::LAST_ROUND) : '0;
    end else begin
      rk_addr = dec ? aes_pkg::ROUND_W'(aes_pkg::LAST_ROUND) - nr : nr;
    end
  end

  assign cmd.load = (st == S_ADD) && !dec;
  assign cmd.step = (st == S_ADD) || (st == S_RUN);
  assign cmd.dec = dec;
  assign cmd.round = rnd;
  assign cmd.key_start = kstart;
  assign cmd.capture = take;
  assign in_ready = (st == S_IDLE) && !stat.key_busy && !cfg_write;
  assign out_valid = out_full;
  assign cfg_ready = (st == S_IDLE);

endmodule

@@ src/aes128_block_cipher.sv @@
`timescale 1ns / 1ps
// channel   | signals                             | item
// s_axis    | s_axis_tvalid/tready/tdata/tuser    | input block, tuser = kind
// m_axis    | m_axis_tvalid/tready/tdata          | result block
// cfg       | cfg_valid/ready/index/data          | key register write
//
// an item runs from accept to result valid as one key addition, ten
// rounds through a single round unit, then a move into the output register
// a new item is taken only once the block is back in idle, after that move
// after reset or a key write the input waits for all round keys, one a cycle
// reset is synchronous; a result holds until m_axis_tready, only a second
// finished item waits on it; key writes are taken only while idle
`include "aes128_block_cipher_defines.svh"
module aes128_block_cipher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // result_high [63:0], result_low [127:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] key_high, key_low;
  logic in_fire, out_fire, cfg_fire;
  aes_pkg::aes_cmd_t cmd;
  aes_pkg::aes_stat_t stat;
  logic [aes_pkg::ROUND_W-1:0] rk_addr;
  logic [127:0] state;

  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        aes_pkg::CFG_KEY_HIGH: key_high <= cfg_data;
        aes_pkg::CFG_KEY_LOW: key_low <= cfg_data;
        default: ;
      endcase
    end
  end

  // input block held for the key addition cycle
  logic [127:0] inreg;
  always_ff @(posedge clk) begin
    if (in_fire) inreg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  end

  aes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_write(cfg_fire), .in_fire(in_fire),
    .in_kind(s_axis_tuser), .out_fire(out_fire), .stat(stat), .cmd(cmd),
    .rk_addr(rk_addr), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
    .cfg_ready(cfg_ready)
  );

  // key addition cycle: encrypt loads block ^ key0; decrypt takes
  // block ^ key10 through inverse shift/sub (round 0 path)
  aes_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .key({key_high, key_low}), .block_in(inreg), .rk_addr(rk_addr),
    .state_out(state)
  );

  assign m_axis_tdata = {state[63:0], state[127:64]};

  `AES_ASSERT_NXT(a_done_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `AES_ASSERT_NXT(a_cfg_blocks_input, clk, rst, cfg_fire, !s_axis_tready)
  `AES_ASSERT_NXT(a_accept_starts, clk, rst, in_fire, !s_axis_tready)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

  // byte i of a block at index i, byte 0 in the top bits
  typedef logic [0:15][7:0] aes_block_t;

  // one row of the directed table
  typedef struct {
    logic [1:0]   key_mask;   // bit 0: write key_high, bit 1: write key_low
    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    logic         kind;
    logic [63:0]  blk_hi;
    logic [63:0]  blk_lo;
    bit           known;      // result typed in below
    logic [127:0] known_out;  // {result_high, result_low}
  } vec_row_t;

  localparam int NUM_RAND = 400;
  localparam int NUM_ROWS = 12;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [63:0]  cfg_data = '0;

  aes128_block_cipher dut (.*);

  always #4 clk = ~clk;

  // predictor state: key registers, round keys and the two s-boxes
  logic [63:0]  key_hi_q, key_lo_q;
  aes_block_t   round_key [aes_pkg::NUM_ROUND_KEYS];
  logic [7:0]   fwd_sb [256];
  logic [7:0]   inv_sb [256];

  // expected output blocks in arrival order, in tdata layout
  logic [127:0] pending_out [$];
  int errors = 0;
  int n_enc = 0, n_dec = 0, n_out = 0, n_keys = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  function automatic logic [7:0] gf_times2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_times2(a);
    end
    return acc;
  endfunction

  // s-boxes from the field inverse (x^254) and the affine map
  task automatic make_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int e = 0; e < 254; e++) inv = gf_prod(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sb[x] = s;
      inv_sb[s] = 8'(x);
    end
  endtask

  task automatic expand_round_keys();
    logic [7:0] rcon, t [4];
    aes_block_t p, k;
    rcon = 8'h01;
    round_key[0] = {key_hi_q, key_lo_q};
    for (int r = 1; r < aes_pkg::NUM_ROUND_KEYS; r++) begin
      p = round_key[r-1];
      t[0] = fwd_sb[p[13]] ^ rcon;
      t[1] = fwd_sb[p[14]];
      t[2] = fwd_sb[p[15]];
      t[3] = fwd_sb[p[12]];
      for (int i = 0; i < 4; i++) k[i] = p[i] ^ t[i];
      for (int c = 1; c < 4; c++)
        for (int i = 0; i < 4; i++) k[c*4+i] = k[(c-1)*4+i] ^ p[c*4+i];
      round_key[r] = k;
      rcon = gf_times2(rcon);
    end
  endtask

  function automatic aes_block_t sub_all(input aes_block_t b, input bit inverse);
    for (int i = 0; i < 16; i++) b[i] = inverse ? inv_sb[b[i]] : fwd_sb[b[i]];
    return b;
  endfunction

  function automatic aes_block_t shift_all(input aes_block_t b, input bit inverse);
    aes_block_t n;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inverse) n[((c+r)&3)*4+r] = b[c*4+r];
        else         n[c*4+r] = b[((c+r)&3)*4+r];
    return n;
  endfunction

  function automatic aes_block_t mix_all(input aes_block_t b, input bit inverse);
    logic [7:0] fwd_m [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
    logic [7:0] inv_m [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    aes_block_t n;
    logic [7:0] acc;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc ^= gf_prod(inverse ? inv_m[(k-r)&3] : fwd_m[(k-r)&3], b[c*4+k]);
        n[c*4+r] = acc;
      end
    return n;
  endfunction

  // full cipher or inverse cipher on {high, low}
  function automatic aes_block_t cipher_block(input logic kind, input aes_block_t b);
    if (kind == aes_pkg::KIND_ENCRYPT) begin
      b ^= round_key[0];
      for (int r = 1; r < aes_pkg::LAST_ROUND; r++)
        b = mix_all(shift_all(sub_all(b, 0), 0), 0) ^ round_key[r];
      b = shift_all(sub_all(b, 0), 0) ^ round_key[aes_pkg::LAST_ROUND];
    end else begin
      b = sub_all(shift_all(b ^ round_key[aes_pkg::LAST_ROUND], 1), 1);
      for (int r = aes_pkg::LAST_ROUND - 1; r > 0; r--)
        b = sub_all(shift_all(mix_all(b ^ round_key[r], 1), 1), 1);
      b ^= round_key[0];
    end
    return b;
  endfunction

  // result side: compare against the oldest expectation, stall at random
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (pending_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata[63:0] !== want[63:0]) begin
          errors++;
          $display("%0t: result_high expected %h actual %h", $time, want[63:0],
                   m_axis_tdata[63:0]);
        end
        if (m_axis_tdata[127:64] !== want[127:64]) begin
          errors++;
          $display("%0t: result_low expected %h actual %h", $time, want[127:64],
                   m_axis_tdata[127:64]);
        end
      end
    end
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // wait for the pipeline to drain plus the item latency
  task automatic drain();
    while (pending_out.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // key register writes, only while idle; mask picks the halves
  task automatic load_key(input logic [1:0] mask, input logic [63:0] hi,
                          input logic [63:0] lo);
    if (mask == 2'b00) return;
    s_axis_tvalid <= 1'b0;
    drain();
    for (int h = 0; h < 2; h++) begin
      if (mask[h]) begin
        cfg_valid <= 1'b1;
        cfg_index <= (h == 0) ? aes_pkg::CFG_KEY_HIGH : aes_pkg::CFG_KEY_LOW;
        cfg_data  <= (h == 0) ? hi : lo;
        do @(posedge clk); while (!cfg_ready);
        if (h == 0) key_hi_q = hi;
        else        key_lo_q = lo;
        expand_round_keys();
        n_keys++;
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // one input item; the expectation is queued at the accepting edge
  task automatic send_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo,
                            input bit known, input logic [127:0] known_out);
    aes_block_t got;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {lo, hi};
    do @(posedge clk); while (!s_axis_tready);
    got = cipher_block(kind, {hi, lo});
    if (known) got = known_out;
    pending_out.push_back({got[8:15], got[0:7]});
    if (kind == aes_pkg::KIND_ENCRYPT) n_enc++;
    else n_dec++;
    // a gap here drops valid; otherwise the next item keeps it high
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  vec_row_t vec_rows [NUM_ROWS] = '{
    // all-zero key after reset, standard known answer and its inverse
    '{2'b00, '0, '0, aes_pkg::KIND_ENCRYPT, '0, '0, 1,
      128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{2'b00, '0, '0, aes_pkg::KIND_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e,
      1, '0},
    // standard appendix vector
    '{2'b11, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, aes_pkg::KIND_ENCRYPT,
      64'h0011223344556677, 64'h8899aabbccddeeff, 1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{2'b00, '0, '0, aes_pkg::KIND_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
      1, 128'h00112233445566778899aabbccddeeff},
    '{2'b00, '0, '0, aes_pkg::KIND_ENCRYPT, ONES, ONES, 0, '0},
    '{2'b00, '0, '0, aes_pkg::KIND_DECRYPT, ONES, ONES, 0, '0},
    // all-ones key
    '{2'b11, ONES, ONES, aes_pkg::KIND_ENCRYPT, '0, '0, 0, '0},
    '{2'b00, '0, '0, aes_pkg::KIND_DECRYPT, ONES, '0, 0, '0},
    '{2'b00, '0, '0, aes_pkg::KIND_ENCRYPT, 64'ha5a5a5a55a5a5a5a, 64'h0f0f0f0ff0f0f0f0,
      0, '0},
    // one half rewritten, the other half kept
    '{2'b01, '0, '0, aes_pkg::KIND_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210,
      0, '0},
    '{2'b10, '0, '0, aes_pkg::KIND_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210,
      0, '0},
    '{2'b00, '0, '0, aes_pkg::KIND_ENCRYPT, ONES, ONES, 0, '0}
  };

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    key_hi_q = '0;
    key_lo_q = '0;
    make_sboxes();
    expand_round_keys();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (16) @(posedge clk);   // key expansion after reset

    // directed part, no idling
    foreach (vec_rows[i]) begin
      load_key(vec_rows[i].key_mask, vec_rows[i].key_hi, vec_rows[i].key_lo);
      send_block(vec_rows[i].kind, vec_rows[i].blk_hi, vec_rows[i].blk_lo,
                 vec_rows[i].known, vec_rows[i].known_out);
    end

    // random part in four idling phases, new key now and then
    for (int n = 0; n < NUM_RAND; n++) begin
      case (n * 4 / NUM_RAND)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (n % 50 == 0) begin
        s_axis_tvalid <= 1'b0;
        load_key(2'($urandom_range(3, 1)), rand_word(), rand_word());
      end
      if (n == NUM_RAND / 2) begin
        // hold off until everything in flight has come back
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
      end
      send_block($urandom_range(1), rand_word(), rand_word(), 0, '0);
    end
    s_axis_tvalid <= 1'b0;

    drain();
    $display("covered %0d encrypt and %0d decrypt items, %0d results, %0d key writes",
             n_enc, n_dec, n_out, n_keys);
    $display("idling phases: none, sender 57%%, receiver 57%%, both 28%%");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
